### rtl/arpc_pkg.sv
// Shared types and constants for the address-resolution cache.
// Used by every module of the block; depends on nothing.
package arpc_pkg;

    localparam int unsigned IP_W   = 32;
    localparam int unsigned MAC_W  = 48;
    localparam int unsigned SLOT_W = 4;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

    typedef enum logic {
        REQ_LEARN   = 1'b0,
        REQ_RESOLVE = 1'b1
    } arpc_req_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_INSERTED = 3'd3,
        ST_REPLACED = 3'd4
    } arpc_status_t;

    // Write command from the decision logic to the table.
    typedef struct packed {
        logic             en;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } arpc_wr_t;

    // One result transfer.
    typedef struct packed {
        arpc_status_t      status;
        logic [MAC_W-1:0]  mac;
        logic [SLOT_W-1:0] slot;
    } arpc_result_t;

endpackage

### rtl/arpc_table.sv
// Entry storage of the cache: valid bits, IP and MAC per entry, parallel IP compare.
// Depends on arpc_pkg.
module arpc_table
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [IP_W-1:0]    key_ip,
    input  logic [ENTRIES-1:0] rd_sel,
    input  arpc_wr_t           wr,
    input  logic [ENTRIES-1:0] wr_sel,
    output logic [ENTRIES-1:0] match_vec,
    output logic [ENTRIES-1:0] free_vec,
    output logic [MAC_W-1:0]   rd_mac
);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [IP_W-1:0]    ip_reg  [ENTRIES];
    logic [MAC_W-1:0]   mac_reg [ENTRIES];

    always_comb begin
        valid_next = valid_reg;
        if (wr.en) begin
            valid_next = valid_reg | wr_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload is only ever read behind a valid bit, so it needs no reset.
    always_ff @(posedge aclk) begin
        for (int k = 0; k < ENTRIES; k++) begin
            if (wr.en && wr_sel[k]) begin
                ip_reg[k]  <= wr.ip;
                mac_reg[k] <= wr.mac;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            match_vec[k] = valid_reg[k] && (ip_reg[k] == key_ip);
        end
    end

    assign free_vec = ~valid_reg;

    // The read select is one-hot or zero, so an OR of gated entries is a clean mux.
    always_comb begin
        rd_mac = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            rd_mac = rd_mac | (mac_reg[k] & {MAC_W{rd_sel[k]}});
        end
    end

endmodule

### rtl/arpc_decide.sv
// Request decision logic: priority selection of hit or free entry and result forming.
// Depends on arpc_pkg.
module arpc_decide
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic               fire,
    input  arpc_req_t          req_type,
    input  logic [IP_W-1:0]    ip_addr,
    input  logic [MAC_W-1:0]   new_mac,
    input  logic [ENTRIES-1:0] match_vec,
    input  logic [ENTRIES-1:0] free_vec,
    input  logic [MAC_W-1:0]   sel_mac,
    output logic [ENTRIES-1:0] hit_oh,
    output arpc_wr_t           wr,
    output logic [ENTRIES-1:0] wr_sel,
    output arpc_result_t       result
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0] free_oh;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   free_idx;
    logic               any_hit;
    logic               any_free;

    // Lowest set bit isolated by the two's-complement trick.
    assign hit_oh   = match_vec & (~match_vec + ENTRIES'(1));
    assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));
    assign any_hit  = |match_vec;
    assign any_free = |free_vec;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (hit_oh[k]) begin
                hit_idx = hit_idx | IDX_W'(k);
            end
            if (free_oh[k]) begin
                free_idx = free_idx | IDX_W'(k);
            end
        end
    end

    always_comb begin
        wr.en         = 1'b0;
        wr.ip         = ip_addr;
        wr.mac        = new_mac;
        wr_sel        = '0;
        result.status = ST_MISS;
        result.mac    = '0;
        result.slot   = '0;
        case (req_type)
            REQ_RESOLVE: begin
                if (any_hit) begin
                    result.status = ST_HIT;
                    result.mac    = sel_mac;
                    result.slot   = SLOT_W'(hit_idx);
                end else begin
                    result.status = ST_MISS;
                    result.mac    = BCAST_MAC;
                end
            end
            REQ_LEARN: begin
                wr.en = fire;
                if (any_hit) begin
                    result.status = ST_UPDATED;
                    result.slot   = SLOT_W'(hit_idx);
                    wr_sel        = hit_oh;
                end else if (any_free) begin
                    result.status = ST_INSERTED;
                    result.slot   = SLOT_W'(free_idx);
                    wr_sel        = free_oh;
                end else begin
                    // Full table: entry zero is overwritten.
                    result.status = ST_REPLACED;
                    wr_sel        = ENTRIES'(1);
                end
            end
            default: begin
                result.status = ST_MISS;
            end
        endcase
    end

endmodule

### rtl/arp_address_cache_core.sv
// Address-resolution cache top level: input register, table with decision logic, result register.
// A request goes from the input register to the result register, which offers its result.
// Throughput: one request per cycle unless stalled; all entries are compared combinationally.
// A learn updates the table at the same edge that loads its result, so the next request sees it.
// Reset: synchronous active-low aresetn clears the pipeline valids and all entry valid bits.
// Depends on arpc_pkg, arpc_table and arpc_decide.
module arp_address_cache_core
    import arpc_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // ip_addr[31:0], new_mac[79:32]
    input  logic        s_axis_tuser,   // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // mac_out[47:0], slot[51:48], zero pad[55:52]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    // Input register stage. Only the valid flag needs reset.
    logic             in_valid_reg;
    logic             in_valid_next;
    arpc_req_t        in_type_reg;
    logic [IP_W-1:0]  in_ip_reg;
    logic [MAC_W-1:0] in_mac_reg;

    // Result register stage.
    logic             out_valid_reg;
    logic             out_valid_next;
    arpc_result_t     out_reg;

    logic               advance;
    logic               fire;
    logic               s_fire;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] hit_oh;
    logic [ENTRIES-1:0] wr_sel;
    logic [MAC_W-1:0]   sel_mac;
    arpc_wr_t           wr;
    arpc_result_t       result;

    // The result register can take a new value when it is empty or being drained.
    // The request held in the input register is processed in the same cycle it
    // moves into the result register, which is also when its table write lands.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_type_reg <= arpc_req_t'(s_axis_tuser);
            in_ip_reg   <= s_axis_tdata[31:0];
            in_mac_reg  <= s_axis_tdata[79:32];
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    arpc_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_ip    (in_ip_reg),
        .rd_sel    (hit_oh),
        .wr        (wr),
        .wr_sel    (wr_sel),
        .match_vec (match_vec),
        .free_vec  (free_vec),
        .rd_mac    (sel_mac)
    );

    arpc_decide #(
        .ENTRIES (ENTRIES)
    ) u_decide (
        .fire      (fire),
        .req_type  (in_type_reg),
        .ip_addr   (in_ip_reg),
        .new_mac   (in_mac_reg),
        .match_vec (match_vec),
        .free_vec  (free_vec),
        .sel_mac   (sel_mac),
        .hit_oh    (hit_oh),
        .wr        (wr),
        .wr_sel    (wr_sel),
        .result    (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.slot, out_reg.mac};
    assign m_axis_tuser  = out_reg.status;

endmodule

### rtl/arpc_checker.sv
// Port-level checker for the address-resolution cache, bound to the top level.
// Depends on arpc_pkg and arp_address_cache_core.
module arpc_assertions
    import arpc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // A resolve miss carries the broadcast MAC and slot zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == ST_MISS) |->
            (m_axis_tdata[47:0] == BCAST_MAC) && (m_axis_tdata[51:48] == 4'd0))
        else $error("miss result without broadcast MAC or with nonzero slot");

    // Learn results carry a zero MAC; a replacement always names entry zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && ((m_axis_tuser == ST_UPDATED) || (m_axis_tuser == ST_INSERTED)
            || (m_axis_tuser == ST_REPLACED)) |->
            (m_axis_tdata[47:0] == '0)
            && ((m_axis_tuser != ST_REPLACED) || (m_axis_tdata[51:48] == 4'd0)))
        else $error("learn result with nonzero MAC or misplaced replacement");

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind arp_address_cache_core arpc_assertions u_arpc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
